>>> design/border_connected_region_fill_assert.svh
// ----------------------------------------------------------------------------
// border connected region fill assertion macros
// shared concurrent assertion forms, clocked on aclk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef BORDER_CONNECTED_REGION_FILL_ASSERT_SVH
`define BORDER_CONNECTED_REGION_FILL_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define BCRF_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define BCRF_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> design/bcrf_pkg.sv
// ----------------------------------------------------------------------------
// bcrf_pkg
// types, constants and helpers shared by the region fill block
// ----------------------------------------------------------------------------
package bcrf_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int LEVEL_W    = $clog2(CELL_COUNT + 1);
    localparam int SIZE_W     = 7;
    localparam int CELL_W     = 2;

    localparam logic [CELL_W-1:0] CELL_CLOSED = 2'd0;
    localparam logic [CELL_W-1:0] CELL_OPEN   = 2'd1;
    localparam logic [CELL_W-1:0] CELL_MARKED = 2'd2;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } grid_req_t;

    // last usable index for a size register: 0 acts as 1, above max acts as max
    function automatic logic [ROW_W-1:0] last_index(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] eff;
        logic [SIZE_W-1:0] lst;
        if (v == '0) begin
            eff = SIZE_W'(1);
        end else if (v > maxv) begin
            eff = maxv;
        end else begin
            eff = v;
        end
        lst = eff - SIZE_W'(1);
        return lst[ROW_W-1:0];
    endfunction

endpackage

>>> design/bcrf_ram.sv
// ----------------------------------------------------------------------------
// bcrf_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bcrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bcrf_fill_seq.sv
// ----------------------------------------------------------------------------
// bcrf_fill_seq
// fill sequencer: border scan, stack driven flood, final relabel sweep
// ----------------------------------------------------------------------------
`include "border_connected_region_fill_assert.svh"

module bcrf_fill_seq
    import bcrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ROW_W-1:0]  nr_last,
    input  logic [COL_W-1:0]  nc_last,
    input  logic [CELL_W-1:0] grid_rdata,
    output grid_req_t         grid_req,
    output logic              busy,
    output logic              done
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BRD_RD  = 4'd1;
    localparam logic [3:0] S_BRD_CHK = 4'd2;
    localparam logic [3:0] S_NEXT    = 4'd3;
    localparam logic [3:0] S_POP_RD  = 4'd4;
    localparam logic [3:0] S_POP_DAT = 4'd5;
    localparam logic [3:0] S_NB_RD   = 4'd6;
    localparam logic [3:0] S_NB_CHK  = 4'd7;
    localparam logic [3:0] S_SWP_RD  = 4'd8;
    localparam logic [3:0] S_SWP_WR  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [ROW_W-1:0]   br_reg, br_next;
    logic [COL_W-1:0]   bc_reg, bc_next;
    logic [ROW_W-1:0]   cr_reg, cr_next;
    logic [COL_W-1:0]   cc_reg, cc_next;
    logic [1:0]         nb_reg, nb_next;
    logic [ADDR_W-1:0]  tgt_reg, tgt_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] level_dec;

    logic               stk_we;
    logic               stk_re;
    logic [ADDR_W-1:0]  stk_rdata;

    logic               nb_ok;
    logic [ROW_W-1:0]   nb_r;
    logic [COL_W-1:0]   nb_c;
    logic               is_open;
    logic               border_row;

    bcrf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (CELL_COUNT)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (level_reg[ADDR_W-1:0]),
        .wdata (tgt_reg),
        .re    (stk_re),
        .raddr (level_dec[ADDR_W-1:0]),
        .rdata (stk_rdata)
    );

    assign level_dec  = level_reg - LEVEL_W'(1);
    assign is_open    = (grid_rdata == CELL_OPEN);
    assign border_row = (br_reg == '0) || (br_reg == nr_last);
    assign busy       = (state_reg != S_IDLE);

    // neighbor order: down, up, right, left
    always_comb begin
        nb_ok = 1'b0;
        nb_r  = cr_reg;
        nb_c  = cc_reg;
        case (nb_reg)
            2'd0: begin
                nb_ok = (cr_reg != nr_last);
                nb_r  = cr_reg + ROW_W'(1);
            end
            2'd1: begin
                nb_ok = (cr_reg != '0);
                nb_r  = cr_reg - ROW_W'(1);
            end
            2'd2: begin
                nb_ok = (cc_reg != nc_last);
                nb_c  = cc_reg + COL_W'(1);
            end
            default: begin
                nb_ok = (cc_reg != '0);
                nb_c  = cc_reg - COL_W'(1);
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        br_next    = br_reg;
        bc_next    = bc_reg;
        cr_next    = cr_reg;
        cc_next    = cc_reg;
        nb_next    = nb_reg;
        tgt_next   = tgt_reg;
        level_next = level_reg;
        grid_req   = '0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        done       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    br_next    = '0;
                    bc_next    = '0;
                    level_next = '0;
                    state_next = S_BRD_RD;
                end
            end
            S_BRD_RD: begin
                grid_req.re    = 1'b1;
                grid_req.raddr = {br_reg, bc_reg};
                tgt_next       = {br_reg, bc_reg};
                state_next     = S_BRD_CHK;
            end
            S_BRD_CHK, S_NB_CHK: begin
                // mark and push an open cell
                if (is_open) begin
                    grid_req.we    = 1'b1;
                    grid_req.waddr = tgt_reg;
                    grid_req.wdata = CELL_MARKED;
                    stk_we         = 1'b1;
                    level_next     = level_reg + LEVEL_W'(1);
                end
                if (state_reg == S_NB_CHK && nb_reg != 2'd3) begin
                    nb_next    = nb_reg + 2'd1;
                    state_next = S_NB_RD;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (level_reg != '0) begin
                    state_next = S_POP_RD;
                end else if (bc_reg == nc_last) begin
                    if (br_reg == nr_last) begin
                        br_next    = '0;
                        bc_next    = '0;
                        state_next = S_SWP_RD;
                    end else begin
                        br_next    = br_reg + ROW_W'(1);
                        bc_next    = '0;
                        state_next = S_BRD_RD;
                    end
                end else if (border_row) begin
                    bc_next    = bc_reg + COL_W'(1);
                    state_next = S_BRD_RD;
                end else begin
                    // inner row: jump to the right edge
                    bc_next    = nc_last;
                    state_next = S_BRD_RD;
                end
            end
            S_POP_RD: begin
                stk_re     = 1'b1;
                level_next = level_dec;
                state_next = S_POP_DAT;
            end
            S_POP_DAT: begin
                cr_next    = stk_rdata[ADDR_W-1:COL_W];
                cc_next    = stk_rdata[COL_W-1:0];
                nb_next    = 2'd0;
                state_next = S_NB_RD;
            end
            S_NB_RD: begin
                if (nb_ok) begin
                    grid_req.re    = 1'b1;
                    grid_req.raddr = {nb_r, nb_c};
                    tgt_next       = {nb_r, nb_c};
                    state_next     = S_NB_CHK;
                end else if (nb_reg == 2'd3) begin
                    state_next = S_NEXT;
                end else begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            S_SWP_RD: begin
                grid_req.re    = 1'b1;
                grid_req.raddr = {br_reg, bc_reg};
                state_next     = S_SWP_WR;
            end
            S_SWP_WR: begin
                grid_req.we    = 1'b1;
                grid_req.waddr = {br_reg, bc_reg};
                grid_req.wdata = (grid_rdata == CELL_MARKED) ? CELL_OPEN : CELL_CLOSED;
                state_next     = S_SWP_RD;
                if (bc_reg == nc_last) begin
                    bc_next = '0;
                    if (br_reg == nr_last) begin
                        state_next = S_DONE;
                    end else begin
                        br_next = br_reg + ROW_W'(1);
                    end
                end else begin
                    bc_next = bc_reg + COL_W'(1);
                end
            end
            S_DONE: begin
                done       = 1'b1;
                level_next = '0;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            level_reg <= '0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
        br_reg  <= br_next;
        bc_reg  <= bc_next;
        cr_reg  <= cr_next;
        cc_reg  <= cc_next;
        nb_reg  <= nb_next;
        tgt_reg <= tgt_next;
    end

    `BCRF_ASSERT(a_no_grid_collision, !(grid_req.we && grid_req.re && grid_req.waddr == grid_req.raddr), "grid read and write hit the same cell")
    `BCRF_ASSERT(a_level_bound, level_reg <= LEVEL_W'(CELL_COUNT), "stack level above cell count")
    `BCRF_ASSERT(a_pop_nonempty, (state_reg != S_POP_RD) || (level_reg != '0), "pop from empty stack")
    `BCRF_ASSERT_NEXT(a_done_idle, done, (state_reg == S_IDLE) && (level_reg == '0), "not idle after done")

endmodule

>>> design/border_connected_region_fill.sv
// ----------------------------------------------------------------------------
// border_connected_region_fill
// binary grid hole fill: cells open if 4-connected to an open border cell
// ----------------------------------------------------------------------------
// write and unused commands: result valid in the cycle after the transfer
// read: result is registered in T_READ from the registered grid ram read
// run: border scan, stack driven flood, then relabel sweep of rows*cols cells,
//   paced by the registered reads of the grid ram and the stack ram
// reset clears control, size registers go to 64 by 64; rams are not cleared
// ----------------------------------------------------------------------------
module border_connected_region_fill
    import bcrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration writes
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [SIZE_W-1:0] cfg_wdata,
    // command stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // row[5:0], col[11:6], cell_open[12], zero
    input  logic [1:0]        s_tuser,   // cmd[1:0]
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata    // read_open[0], done_res[1], zero
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_READ = 2'd1;
    localparam logic [1:0] T_RUN  = 2'd2;

    logic [1:0]        tstate_reg, tstate_next;
    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic              in_grid_reg, in_grid_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_rd_reg, m_rd_next;

    logic [ROW_W-1:0]  nr_last;
    logic [COL_W-1:0]  nc_last;

    // unpacked command fields
    logic [1:0]        s_cmd;
    logic [ROW_W-1:0]  s_row;
    logic [COL_W-1:0]  s_col;
    logic              s_open;
    logic              in_xfer;
    logic              in_grid;

    grid_req_t         cmd_req;
    grid_req_t         seq_req;
    grid_req_t         grid_req;
    logic [CELL_W-1:0] grid_rdata;
    logic              seq_start;
    logic              seq_busy;
    logic              seq_done;

    assign s_cmd  = s_tuser;
    assign s_row  = s_tdata[ROW_W-1:0];
    assign s_col  = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign s_open = s_tdata[ROW_W+COL_W];

    // effective grid size, out of range sizes clamp
    assign nr_last = last_index(rows_reg, SIZE_W'(MAX_ROWS));
    assign nc_last = COL_W'(last_index(cols_reg, SIZE_W'(MAX_COLS)));

    // one command at a time; the output register may drain in the same cycle
    assign s_tready = (tstate_reg == T_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_grid  = (s_row <= nr_last) && (s_col <= nc_last);

    assign seq_start = in_xfer && (s_cmd == CMD_RUN);

    // grid port belongs to the sequencer while a run is going on
    assign grid_req = seq_busy ? seq_req : cmd_req;

    bcrf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .aclk  (aclk),
        .we    (grid_req.we),
        .waddr (grid_req.waddr),
        .wdata (grid_req.wdata),
        .re    (grid_req.re),
        .raddr (grid_req.raddr),
        .rdata (grid_rdata)
    );

    bcrf_fill_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (seq_start),
        .nr_last    (nr_last),
        .nc_last    (nc_last),
        .grid_rdata (grid_rdata),
        .grid_req   (seq_req),
        .busy       (seq_busy),
        .done       (seq_done)
    );

    always_comb begin
        cmd_req       = '0;
        tstate_next   = tstate_reg;
        in_grid_next  = in_grid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_rd_next     = m_rd_reg;
        case (tstate_reg)
            T_IDLE: begin
                if (in_xfer) begin
                    case (s_cmd)
                        CMD_WRITE: begin
                            // writes outside the grid in use are dropped
                            cmd_req.we    = in_grid;
                            cmd_req.waddr = {s_row, s_col};
                            cmd_req.wdata = s_open ? CELL_OPEN : CELL_CLOSED;
                            m_tvalid_next = 1'b1;
                            m_rd_next     = 1'b0;
                        end
                        CMD_RUN: begin
                            tstate_next = T_RUN;
                        end
                        CMD_READ: begin
                            cmd_req.re    = 1'b1;
                            cmd_req.raddr = {s_row, s_col};
                            in_grid_next  = in_grid;
                            tstate_next   = T_READ;
                        end
                        default: begin
                            // unused command completes with no effect
                            m_tvalid_next = 1'b1;
                            m_rd_next     = 1'b0;
                        end
                    endcase
                end
            end
            T_READ: begin
                // output register was emptied at the command transfer
                m_tvalid_next = 1'b1;
                m_rd_next     = in_grid_reg && (grid_rdata != CELL_CLOSED);
                tstate_next   = T_IDLE;
            end
            T_RUN: begin
                if (seq_done) begin
                    m_tvalid_next = 1'b1;
                    m_rd_next     = 1'b0;
                    tstate_next   = T_IDLE;
                end
            end
            default: begin
                tstate_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tstate_reg   <= T_IDLE;
            m_tvalid_reg <= 1'b0;
            rows_reg     <= SIZE_W'(MAX_ROWS);
            cols_reg     <= SIZE_W'(MAX_COLS);
        end else begin
            tstate_reg   <= tstate_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ROWS: rows_reg <= cfg_wdata;
                    REG_COLS: cols_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        in_grid_reg <= in_grid_next;
        m_rd_reg    <= m_rd_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, 1'b1, m_rd_reg};

endmodule
